// ===== hw/rtl/observer_controller_secant_step_top_assert.svh =====
// Assertion macros for the observer controller RTL.
`ifndef OBSERVER_CONTROLLER_SECANT_STEP_TOP_ASSERT_SVH
`define OBSERVER_CONTROLLER_SECANT_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define OCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on clk_i, also while reset is held.
`define OCSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OCSS_ASSERT(lbl, prop, msg)
`define OCSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/ocss_pkg.sv =====
// Types, register map and microcode for the observer controller secant step.
package ocss_pkg;

  localparam int WordW   = 32;
  localparam int AddrW   = 5;
  localparam int NumRegs = 32;
  localparam int CfgIdxW = 4;
  localparam int NumCfg  = 8;
  localparam int PcW     = 6;

  // Command codes
  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_TICK  = 2'd1;
  localparam logic [1:0] OPC_STOP  = 2'd2;

  // Result kinds
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [WordW-1:0] setpoint;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic signed [WordW-1:0] drive_value;
    logic                    solve_failed;
  } out_item_t;

  // Register file map; the config registers sit at their own index
  localparam logic [AddrW-1:0] R_OG     = 5'd0;
  localparam logic [AddrW-1:0] R_OFG    = 5'd1;
  localparam logic [AddrW-1:0] R_DFG    = 5'd2;
  localparam logic [AddrW-1:0] R_B2     = 5'd3;
  localparam logic [AddrW-1:0] R_B1     = 5'd4;
  localparam logic [AddrW-1:0] R_B0     = 5'd5;
  localparam logic [AddrW-1:0] R_A1     = 5'd6;
  localparam logic [AddrW-1:0] R_A0     = 5'd7;
  localparam logic [AddrW-1:0] R_OFS    = 5'd8;
  localparam logic [AddrW-1:0] R_DFS    = 5'd9;
  localparam logic [AddrW-1:0] R_PS1    = 5'd10;
  localparam logic [AddrW-1:0] R_PS2    = 5'd11;
  localparam logic [AddrW-1:0] R_SOLVED = 5'd12;
  localparam logic [AddrW-1:0] R_SP     = 5'd13;
  localparam logic [AddrW-1:0] R_X0     = 5'd14;
  localparam logic [AddrW-1:0] R_X1     = 5'd15;
  localparam logic [AddrW-1:0] R_X2     = 5'd16;
  localparam logic [AddrW-1:0] R_F0     = 5'd17;
  localparam logic [AddrW-1:0] R_F1     = 5'd18;
  localparam logic [AddrW-1:0] R_T      = 5'd19;
  localparam logic [AddrW-1:0] R_U      = 5'd20;
  localparam logic [AddrW-1:0] R_O      = 5'd21;
  localparam logic [AddrW-1:0] R_DRV    = 5'd22;
  localparam logic [AddrW-1:0] R_ZERO   = 5'd23;  // never written, reads 0

  typedef enum logic [3:0] {
    UOP_MUL, UOP_ADD, UOP_SUB, UOP_MULN, UOP_DIV, UOP_ONE, UOP_TOL,
    UOP_BRZ, UOP_LOOP, UOP_END
  } uop_e;

  typedef struct packed {
    uop_e             op;
    logic [AddrW-1:0] dst;
    logic [AddrW-1:0] ra;
    logic [AddrW-1:0] rb;
  } uinstr_t;

  // Program entry points
  localparam logic [PcW-1:0] PC_START = 6'd0;
  localparam logic [PcW-1:0] PC_TICK  = 6'd7;
  localparam logic [PcW-1:0] PC_LOOP  = 6'd10;
  localparam logic [PcW-1:0] PC_SOLVE = 6'd34;

  typedef struct packed {
    logic             start;     // capture setpoint, clear saturation and fail flags
    logic             fetch;     // register operand read
    logic             exec;      // operate on operands
    logic             wb;        // write back result
    uop_e             op;
    logic [AddrW-1:0] ra;
    logic [AddrW-1:0] rb;
    logic [AddrW-1:0] dst;
    logic             set_fail;
    logic             load_out;
    logic             out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic lt;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  function automatic uinstr_t mk(input uop_e op, input logic [AddrW-1:0] dst,
                                 input logic [AddrW-1:0] ra, input logic [AddrW-1:0] rb);
    uinstr_t u;
    u.op  = op;
    u.dst = dst;
    u.ra  = ra;
    u.rb  = rb;
    return u;
  endfunction

  function automatic uinstr_t ucode(input logic [PcW-1:0] pc);
    uinstr_t u;
    case (pc)
      // start: drive from the last solution
      6'd0:  u = mk(UOP_MUL, R_T, R_OG, R_SOLVED);
      6'd1:  u = mk(UOP_ADD, R_O, R_T, R_OFS);
      6'd2:  u = mk(UOP_MUL, R_OFS, R_SOLVED, R_OFG);
      6'd3:  u = mk(UOP_SUB, R_T, R_SP, R_O);
      6'd4:  u = mk(UOP_SUB, R_DRV, R_T, R_DFS);
      6'd5:  u = mk(UOP_MUL, R_DFS, R_DRV, R_DFG);
      6'd6:  u = mk(UOP_END, R_ZERO, R_ZERO, R_ZERO);
      // tick: secant search setup
      6'd7:  u = mk(UOP_ADD, R_X0, R_ZERO, R_ZERO);
      6'd8:  u = mk(UOP_ONE, R_X1, R_ZERO, R_ZERO);
      6'd9:  u = mk(UOP_ADD, R_X2, R_ZERO, R_ZERO);
      // residual of x0
      6'd10: u = mk(UOP_MUL, R_T, R_OG, R_X0);
      6'd11: u = mk(UOP_ADD, R_T, R_T, R_OFS);
      6'd12: u = mk(UOP_SUB, R_T, R_SP, R_T);
      6'd13: u = mk(UOP_SUB, R_T, R_T, R_DFS);
      6'd14: u = mk(UOP_MUL, R_T, R_B2, R_T);
      6'd15: u = mk(UOP_ADD, R_T, R_T, R_PS1);
      6'd16: u = mk(UOP_SUB, R_F0, R_X0, R_T);
      // residual of x1
      6'd17: u = mk(UOP_MUL, R_T, R_OG, R_X1);
      6'd18: u = mk(UOP_ADD, R_T, R_T, R_OFS);
      6'd19: u = mk(UOP_SUB, R_T, R_SP, R_T);
      6'd20: u = mk(UOP_SUB, R_T, R_T, R_DFS);
      6'd21: u = mk(UOP_MUL, R_T, R_B2, R_T);
      6'd22: u = mk(UOP_ADD, R_T, R_T, R_PS1);
      6'd23: u = mk(UOP_SUB, R_F1, R_X1, R_T);
      // secant step
      6'd24: u = mk(UOP_SUB, R_T, R_F1, R_F0);
      6'd25: u = mk(UOP_BRZ, R_ZERO, R_ZERO, R_ZERO);
      6'd26: u = mk(UOP_SUB, R_U, R_X1, R_X0);
      6'd27: u = mk(UOP_MULN, R_ZERO, R_F0, R_U);
      6'd28: u = mk(UOP_DIV, R_O, R_T, R_ZERO);
      6'd29: u = mk(UOP_SUB, R_X2, R_X0, R_O);
      6'd30: u = mk(UOP_TOL, R_ZERO, R_X2, R_X1);
      6'd31: u = mk(UOP_ADD, R_X0, R_X1, R_ZERO);
      6'd32: u = mk(UOP_ADD, R_X1, R_X2, R_ZERO);
      6'd33: u = mk(UOP_LOOP, R_ZERO, R_ZERO, R_ZERO);
      // state update with the solution
      6'd34: u = mk(UOP_ADD, R_SOLVED, R_X2, R_ZERO);
      6'd35: u = mk(UOP_MUL, R_T, R_OG, R_X2);
      6'd36: u = mk(UOP_ADD, R_O, R_T, R_OFS);
      6'd37: u = mk(UOP_MUL, R_OFS, R_X2, R_OFG);
      6'd38: u = mk(UOP_SUB, R_T, R_SP, R_O);
      6'd39: u = mk(UOP_SUB, R_DRV, R_T, R_DFS);
      6'd40: u = mk(UOP_MUL, R_DFS, R_DRV, R_DFG);
      6'd41: u = mk(UOP_MUL, R_T, R_B1, R_DRV);
      6'd42: u = mk(UOP_MUL, R_U, R_A1, R_X2);
      6'd43: u = mk(UOP_SUB, R_T, R_T, R_U);
      6'd44: u = mk(UOP_ADD, R_PS1, R_T, R_PS2);
      6'd45: u = mk(UOP_MUL, R_T, R_B0, R_DRV);
      6'd46: u = mk(UOP_MUL, R_U, R_A0, R_X2);
      6'd47: u = mk(UOP_SUB, R_PS2, R_T, R_U);
      default: u = mk(UOP_END, R_ZERO, R_ZERO, R_ZERO);
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/ocss_div.sv =====
// Radix-2 restoring divider: signed 64-bit by 32-bit, truncating quotient.
module ocss_div import ocss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  logic [63:0] q_q, q_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dm_q;
  logic        neg_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_sh;

  // One quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[31:0], q_q[63]};
    q_d    = {q_q[62:0], 1'b0};
    rem_d  = rem_sh;
    if (rem_sh >= {1'b0, dm_q}) begin
      rem_d   = rem_sh - {1'b0, dm_q};
      q_d[0]  = 1'b1;
    end
  end

  // Operand load and iteration
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i[63] ? 64'(-num_i) : num_i;
      dm_q  <= den_i[31] ? 32'(-den_i) : den_i;
      neg_q <= num_i[63] ^ den_i[31];
      rem_q <= '0;
    end else if (busy_q) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 64'(-q_q) : q_q;

endmodule

// ===== hw/rtl/ocss_datapath.sv =====
// Datapath: register file, shared multiplier and adder, divider, result register.
module ocss_datapath import ocss_pkg::*; #(
  parameter int FractionBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [WordW-1:0]     cfg_data_i,
  input  logic signed [WordW-1:0] setpoint_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_item_t            out_item_o
);

  localparam logic [WordW-1:0] One = WordW'(1) << FractionBits;
  localparam int TolRaw = ((1 << FractionBits) + 5000) / 10000;
  localparam int Tol    = (TolRaw < 1) ? 1 : TolRaw;
  localparam logic [33:0] TolV = 34'(Tol);

  function automatic logic [WordW-1:0] sat_w(input logic signed [63:0] v);
    logic [WordW-1:0] r;
    if (v > 64'sd2147483647) r = 32'h7fffffff;
    else if (v < -64'sd2147483648) r = 32'h80000000;
    else r = v[WordW-1:0];
    return r;
  endfunction

  function automatic logic ovf_w(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  logic [WordW-1:0]        rf_q [NumRegs];
  logic [NumRegs-1:0]      vld_q;
  logic                    we;
  logic [AddrW-1:0]        waddr;
  logic [WordW-1:0]        wdata;
  logic signed [WordW-1:0] opa_q, opb_q;
  logic signed [63:0]      prod_q, num_q, wide, quot;
  logic signed [32:0]      sum_q;
  logic signed [33:0]      diff;
  logic [33:0]             mag;
  logic [WordW-1:0]        wb_val, drv_q;
  logic                    wb_wr, wb_sat, zero_q, sat_q, fail_q, div_done;
  logic                    out_valid_q;
  out_item_t               out_q;

  // Write-back value
  always_comb begin
    case (cmd_i.op)
      UOP_MUL:                   wide = prod_q >>> FractionBits;
      UOP_ADD, UOP_SUB, UOP_TOL: wide = {{31{sum_q[32]}}, sum_q};
      UOP_DIV:                   wide = quot;
      UOP_ONE:                   wide = {32'd0, One};
      default:                   wide = '0;
    endcase
    wb_val = sat_w(wide);
    wb_wr  = (cmd_i.op == UOP_MUL) || (cmd_i.op == UOP_ADD) || (cmd_i.op == UOP_SUB) ||
             (cmd_i.op == UOP_DIV) || (cmd_i.op == UOP_ONE);
    wb_sat = ovf_w(wide) && ((cmd_i.op == UOP_MUL) || (cmd_i.op == UOP_ADD) ||
             (cmd_i.op == UOP_SUB) || (cmd_i.op == UOP_DIV));
  end

  // Single write port: config, setpoint capture, write-back
  always_comb begin
    we    = 1'b0;
    waddr = R_ZERO;
    wdata = wb_val;
    if (cfg_we_i && (cfg_index_i < CfgIdxW'(NumCfg))) begin
      we    = 1'b1;
      waddr = AddrW'(cfg_index_i);
      wdata = cfg_data_i;
    end else if (cmd_i.start) begin
      we    = 1'b1;
      waddr = R_SP;
      wdata = setpoint_i;
    end else if (cmd_i.wb && wb_wr) begin
      we    = 1'b1;
      waddr = cmd_i.dst;
    end
  end

  // Register file storage
  always_ff @(posedge clk_i) begin
    if (we) rf_q[waddr] <= wdata;
  end

  // Entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (we) vld_q[waddr] <= 1'b1;
  end

  // Registered operand read
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      opa_q <= vld_q[cmd_i.ra] ? rf_q[cmd_i.ra] : '0;
      opb_q <= vld_q[cmd_i.rb] ? rf_q[cmd_i.rb] : '0;
    end
  end

  // Multiply and add stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      prod_q <= opa_q * opb_q;
      sum_q  <= (cmd_i.op == UOP_ADD) ? ({opa_q[31], opa_q} + {opb_q[31], opb_q})
                                      : ({opa_q[31], opa_q} - {opb_q[31], opb_q});
    end
    if (cmd_i.wb && (cmd_i.op == UOP_MULN)) num_q <= prod_q;
    if (cmd_i.wb && (cmd_i.dst == R_DRV) && wb_wr) drv_q <= wb_val;
  end

  ocss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.exec && (cmd_i.op == UOP_DIV)),
    .num_i  (num_q),
    .den_i  (opa_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Convergence test on the exact difference
  assign diff = {sum_q[32], sum_q};
  assign mag  = diff[33] ? 34'(-diff) : diff;

  // Flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
      sat_q  <= 1'b0;
      fail_q <= 1'b0;
    end else if (cmd_i.start) begin
      sat_q  <= 1'b0;
      fail_q <= 1'b0;
    end else begin
      if (cmd_i.wb && wb_wr) zero_q <= (wb_val == '0);
      if (cmd_i.wb && wb_sat) sat_q <= 1'b1;
      if (cmd_i.set_fail) fail_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.result_kind  <= cmd_i.out_kind;
      out_q.drive_value  <= (cmd_i.out_kind == KIND_ACK) ? '0 : drv_q;
      out_q.solve_failed <= (cmd_i.out_kind == KIND_DRIVE) && (sat_q || fail_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;
  assign status_o.zero     = zero_q;
  assign status_o.lt       = mag < TolV;
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && out_stall_i;

endmodule

// ===== hw/rtl/ocss_ctrl.sv =====
// Controller: command decode, microcode sequencer and secant iteration count.
module ocss_ctrl import ocss_pkg::*; #(
  parameter int MaxIt = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);
  `include "observer_controller_secant_step_top_assert.svh"

  localparam int IterW = (MaxIt > 1) ? $clog2(MaxIt) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ISSUE  = 6'b000010,
    S_EXEC   = 6'b000100,
    S_WB     = 6'b001000,
    S_DIVW   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             running_q, running_d;
  logic             kind_q, kind_d;
  uinstr_t          u;
  dp_cmd_t          cmd;

  assign u = ucode(pc_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    iter_d       = iter_q;
    running_d    = running_q;
    kind_d       = kind_q;
    cmd          = '0;
    cmd.op       = u.op;
    cmd.ra       = u.ra;
    cmd.rb       = u.rb;
    cmd.dst      = u.dst;
    cmd.out_kind = kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OPC_START: begin
              running_d = 1'b1;
              pc_d      = PC_START;
              cmd.start = 1'b1;
              state_d   = S_ISSUE;
            end
            OPC_TICK: begin
              if (running_q) begin
                pc_d      = PC_TICK;
                iter_d    = '0;
                cmd.start = 1'b1;
                state_d   = S_ISSUE;
              end
            end
            OPC_STOP: begin
              running_d = 1'b0;
              kind_d    = KIND_ACK;
              state_d   = S_RESULT;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        case (u.op)
          UOP_BRZ: begin
            if (status_i.zero) begin
              cmd.set_fail = 1'b1;
              pc_d         = PC_SOLVE;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          UOP_LOOP: begin
            if (iter_q == IterW'(MaxIt - 1)) begin
              pc_d = PC_SOLVE;
            end else begin
              iter_d = iter_q + 1'b1;
              pc_d   = PC_LOOP;
            end
          end
          UOP_END: begin
            kind_d  = KIND_DRIVE;
            state_d = S_RESULT;
          end
          default: begin
            cmd.fetch = 1'b1;
            state_d   = S_EXEC;
          end
        endcase
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_d  = (u.op == UOP_DIV) ? S_DIVW : S_WB;
      end
      S_DIVW: begin
        if (status_i.div_done) state_d = S_WB;
      end
      S_WB: begin
        cmd.wb  = 1'b1;
        pc_d    = ((u.op == UOP_TOL) && status_i.lt) ? PC_SOLVE : pc_q + 1'b1;
        state_d = S_ISSUE;
      end
      S_RESULT: begin
        if (!status_i.out_busy) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      iter_q    <= '0;
      running_q <= 1'b0;
      kind_q    <= KIND_DRIVE;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      iter_q    <= iter_d;
      running_q <= running_d;
      kind_q    <= kind_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd;

  `OCSS_ASSERT(a_iter_range, iter_q <= IterW'(MaxIt - 1), "iteration count past limit")
  `OCSS_ASSERT(a_out_free, cmd.load_out |-> !status_i.out_busy, "result overwrote pending transfer")
  `OCSS_ASSERT(a_div_wait, (state_q == S_DIVW && status_i.div_done) |=> state_q == S_WB, "divide result not written back")
  `OCSS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == S_IDLE, "controller busy in reset")

endmodule

// ===== hw/rtl/observer_controller_secant_step_top.sv =====
// Observer controller with secant solve of the algebraic loop.
// Start: drive from the last solution; stop: ack; tick: setup plus, per secant
// iteration, the two residuals and the secant step with a divide, then 14 steps.
// One item at a time: the input stalls while the sequencer is busy.
// Reset (async, active low) clears the running flag and all control state; registers, config included, read zero.
module observer_controller_secant_step_top import ocss_pkg::*; #(
  parameter int MAX_ITERATIONS = 20,
  parameter int FRACTION_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  ocss_ctrl #(.MaxIt(MAX_ITERATIONS)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i  (in_item_i.opcode),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ocss_datapath #(.FractionBits(FRACTION_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .setpoint_i (in_item_i.setpoint),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

// ===== sim/ocss_drive_checker.sv =====
// Checker for the observer controller: predicts each result and compares it.
`timescale 1ns / 100ps

module ocss_drive_checker import ocss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 failed_seen_o
);

  localparam int Frac    = 16;
  localparam int MaxIter = 20;
  localparam longint Tol = ((longint'(1) << Frac) + 5000) / 10000;

  typedef logic signed [31:0] fix_t;

  // Shadow configuration
  fix_t og, ofg, dfg, b2, b1, b0, a1, a0;
  // Shadow state
  logic running;
  fix_t ofs, dfs, ps1, ps2, solved;
  logic clipped;

  out_item_t drive_due[$];

  function automatic fix_t clip(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) begin
      clipped = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -longint'(32'sh7FFFFFFF) - 1) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return fix_t'(v);
  endfunction

  function automatic fix_t fmul(input fix_t a, input fix_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip(p >>> Frac);
  endfunction

  function automatic fix_t fadd(input fix_t a, input fix_t b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic fix_t fsub(input fix_t a, input fix_t b);
    return clip(longint'(a) - longint'(b));
  endfunction

  // Loop residual for a trial plant output; only the clipped flag can change
  function automatic fix_t loop_residual(input fix_t sp, input fix_t x);
    fix_t o, u;
    o = fadd(fmul(og, x), ofs);
    u = fsub(fsub(sp, o), dfs);
    return fsub(x, fadd(fmul(b2, u), ps1));
  endfunction

  // Output filter then drive filter, both states advanced
  function automatic fix_t filter_drive(input fix_t sp, input fix_t y);
    fix_t o, u;
    o   = fadd(fmul(og, y), ofs);
    ofs = fmul(y, ofg);
    u   = fsub(fsub(sp, o), dfs);
    dfs = fmul(u, dfg);
    return u;
  endfunction

  // Secant solve of y = plant(drive(y)); den_zero flags a flat residual
  function automatic fix_t solve_output(input fix_t sp, output logic den_zero);
    fix_t x0, x1, x2, f0, f1, den;
    longint num, q, d;
    x0 = '0;
    x1 = fix_t'(longint'(1) << Frac);
    x2 = '0;
    den_zero = 1'b0;
    for (int it = 0; it < MaxIter; it++) begin
      f0  = loop_residual(sp, x0);
      f1  = loop_residual(sp, x1);
      den = fsub(f1, f0);
      if (den == 0) begin
        den_zero = 1'b1;
        break;
      end
      num = longint'(f0) * longint'(fsub(x1, x0));
      q   = num / longint'(den);
      x2  = fsub(x0, clip(q));
      d   = longint'(x2) - longint'(x1);
      if (d < 0) d = -d;
      if (d < Tol) break;
      x0 = x1;
      x1 = x2;
    end
    return x2;
  endfunction

  // Advance the shadow block by one command; returns 1 if a result is due
  function automatic logic predict_command(input in_item_t cmd, output out_item_t res);
    fix_t y, drv;
    logic den_zero;
    clipped  = 1'b0;
    den_zero = 1'b0;
    res      = '0;
    case (cmd.opcode)
      OPC_START: begin
        running = 1'b1;
        drv = filter_drive(cmd.setpoint, solved);
      end
      OPC_TICK: begin
        if (!running) return 1'b0;
        y      = solve_output(cmd.setpoint, den_zero);
        solved = y;
        drv    = filter_drive(cmd.setpoint, y);
        ps1    = fadd(fsub(fmul(b1, drv), fmul(a1, y)), ps2);
        ps2    = fsub(fmul(b0, drv), fmul(a0, y));
      end
      OPC_STOP: begin
        running = 1'b0;
        res.result_kind = KIND_ACK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    res.result_kind  = KIND_DRIVE;
    res.drive_value  = drv;
    res.solve_failed = den_zero | clipped;
    return 1'b1;
  endfunction

  assign pending_o = drive_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    out_item_t new_item;
    if (!rst_ni) begin
      {og, ofg, dfg, b2, b1, b0, a1, a0} = '0;
      {ofs, dfs, ps1, ps2, solved} = '0;
      running = 1'b0;
      drive_due.delete();
      error_count_o = 0;
      checked_o     = 0;
      failed_seen_o = 0;
    end else begin
      // Result transfer: compare against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (drive_due.size() == 0) begin
          $error("unexpected result kind=%0d drive=%0d", out_item_i.result_kind,
                 out_item_i.drive_value);
          error_count_o++;
        end else begin
          exp_item = drive_due.pop_front();
          checked_o++;
          if (out_item_i.solve_failed) failed_seen_o++;
          if (out_item_i.result_kind !== exp_item.result_kind) begin
            $error("result_kind exp %0d got %0d", exp_item.result_kind,
                   out_item_i.result_kind);
            error_count_o++;
          end
          if (out_item_i.drive_value !== exp_item.drive_value) begin
            $error("drive_value exp %0d got %0d", exp_item.drive_value,
                   out_item_i.drive_value);
            error_count_o++;
          end
          if (out_item_i.solve_failed !== exp_item.solve_failed) begin
            $error("solve_failed exp %0d got %0d", exp_item.solve_failed,
                   out_item_i.solve_failed);
            error_count_o++;
          end
        end
      end
      // Command transfer
      if (in_valid_i && !in_stall_i) begin
        if (predict_command(in_item_i, new_item)) drive_due.push_back(new_item);
      end
      // Register write; indexes past the map are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          R_OG[CfgIdxW-1:0]:  og  = cfg_data_i;
          R_OFG[CfgIdxW-1:0]: ofg = cfg_data_i;
          R_DFG[CfgIdxW-1:0]: dfg = cfg_data_i;
          R_B2[CfgIdxW-1:0]:  b2  = cfg_data_i;
          R_B1[CfgIdxW-1:0]:  b1  = cfg_data_i;
          R_B0[CfgIdxW-1:0]:  b0  = cfg_data_i;
          R_A1[CfgIdxW-1:0]:  a1  = cfg_data_i;
          R_A0[CfgIdxW-1:0]:  a0  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: stimulus, handshake idling and verdict for the observer controller.
`timescale 1ns / 100ps

module tb import ocss_pkg::*;;

  localparam int SettleCycles = 3000;
  localparam int StallLimit   = 20000;
  localparam int HoldCycles   = 400;
  localparam int RandPerPhase = 65;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WordW-1:0]   cfg_data_i = '0;

  int error_count, pending, checked, failed_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent = 0;
  logic running_guess = 1'b0;

  always #5 clk_i = ~clk_i;

  observer_controller_secant_step_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i, .out_valid_o, .out_stall_i,
    .out_item_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  ocss_drive_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .error_count_o(error_count), .pending_o(pending), .checked_o(checked),
    .failed_seen_o(failed_seen)
  );

  // Receiver: random stall, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d pending", StallLimit, pending);
      $display("tb: errors");
      $finish;
    end
  end

  // One command transfer, with optional idle cycles in front
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i.opcode = op;
    in_item_i.setpoint = sp;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op == OPC_START) running_guess = 1'b1;
    if (op == OPC_STOP) running_guess = 1'b0;
    sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drain results, let a silent command finish, then load all gains
  task automatic load_gains(input logic [31:0] g[8]);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    write_reg(R_OG[CfgIdxW-1:0], g[0]);
    write_reg(R_OFG[CfgIdxW-1:0], g[1]);
    write_reg(R_DFG[CfgIdxW-1:0], g[2]);
    write_reg(R_B2[CfgIdxW-1:0], g[3]);
    write_reg(R_B1[CfgIdxW-1:0], g[4]);
    write_reg(R_B0[CfgIdxW-1:0], g[5]);
    write_reg(R_A1[CfgIdxW-1:0], g[6]);
    write_reg(R_A0[CfgIdxW-1:0], g[7]);
  endtask

  function automatic logic [31:0] rand_setpoint();
    if ($urandom_range(9) < 7) return 32'($urandom_range(1 << 19) - (1 << 18));
    return $urandom;
  endfunction

  // Mostly gains within about +-2.0, now and then any 32-bit value
  function automatic logic [31:0] rand_gain();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(1 << 18) - (1 << 17));
  endfunction

  initial begin
    logic [31:0] g[8];
    logic [1:0] op;
    int r;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset gains, tick while stopped, unused opcode, start/tick/stop
    send_cmd(OPC_TICK, 32'h0001_0000);
    send_cmd(2'd3, 32'hFFFF_FFFF);
    send_cmd(OPC_START, 32'h7FFF_FFFF);
    send_cmd(OPC_TICK, 32'h8000_0000);
    send_cmd(OPC_TICK, 32'h0000_0000);
    send_cmd(OPC_STOP, 32'h1234_5678);
    send_cmd(OPC_TICK, 32'h0002_0000);

    // Directed: all gains at the positive extreme, then the negative one
    foreach (g[i]) g[i] = 32'h7FFF_FFFF;
    load_gains(g);
    write_reg(CfgIdxW'(NumCfg), 32'hFFFF_FFFF);
    write_reg(CfgIdxW'(NumCfg + 7), 32'hA5A5_A5A5);
    send_cmd(OPC_START, 32'h7FFF_FFFF);
    send_cmd(OPC_TICK, 32'h8000_0000);
    send_cmd(OPC_TICK, 32'h7FFF_FFFF);
    send_cmd(OPC_STOP, 32'h0);
    foreach (g[i]) g[i] = 32'h8000_0000;
    load_gains(g);
    send_cmd(OPC_START, 32'h8000_0000);
    send_cmd(OPC_TICK, 32'h7FFF_FFFF);
    send_cmd(OPC_TICK, 32'hFFFF_FFFF);
    send_cmd(OPC_STOP, 32'h0);

    // Directed: a tame loop that converges
    g = '{32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000,
          32'h0000_1000, 32'h0000_0800, 32'hFFFF_8000, 32'h0000_4000};
    load_gains(g);
    send_cmd(OPC_START, 32'h0001_0000);
    send_cmd(OPC_TICK, 32'h0001_0000);
    send_cmd(OPC_TICK, 32'hFFFE_0000);
    send_cmd(OPC_TICK, 32'h0000_0001);

    // Random phases with new gains; idling pattern shifts every two phases
    for (int ph = 0; ph < 6; ph++) begin
      foreach (g[i]) g[i] = rand_gain();
      if (ph == 3) g[3] = 32'h0;
      load_gains(g);
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 27 : 0;
      for (int n = 0; n < RandPerPhase; n++) begin
        if (ph == 4 && n == 10) hold_req = 1'b1;
        r = $urandom_range(99);
        if (!running_guess) op = (r < 80) ? OPC_START : (r < 90) ? OPC_TICK : 2'd3;
        else op = (r < 80) ? OPC_TICK : (r < 88) ? OPC_START : (r < 96) ? OPC_STOP : 2'd3;
        send_cmd(op, rand_setpoint());
      end
    end

    // Drain and let the last command settle
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    $display("run: %0d commands sent under reset gains and 9 loaded gain sets, %0d checked",
             sent, checked);
    $display("run: %0d results reported a failed or clipped solve", failed_seen);
    if (error_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ocss_pkg.sv
hw/rtl/ocss_div.sv
hw/rtl/ocss_datapath.sv
hw/rtl/ocss_ctrl.sv
hw/rtl/observer_controller_secant_step_top.sv
sim/ocss_drive_checker.sv
sim/tb.sv
